// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every edge outside reset
`define BLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition leads to another in the next cycle
`define BLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/blp_pkg.sv =====
// ----------------------------------------------------------------------------
// blp_pkg
// Shared constants and types of the beam likelihood product unit.
// ----------------------------------------------------------------------------
package blp_pkg;

  localparam int RANGE_BINS_DEF = 256;

  localparam logic [1:0] CFG_PIXELS_PER_METRE = 2'd0;
  localparam logic [1:0] CFG_RANGE_LIMIT      = 2'd1;

  localparam logic [15:0] PPM_RESET   = 16'd5120;
  localparam logic [8:0]  MAXR_RESET  = 9'd256;

  localparam logic        FUNC_LOAD   = 1'b0;
  localparam logic        FUNC_WEIGH  = 1'b1;

  localparam logic [31:0] MANT_ONE    = 32'h8000_0000;
  localparam logic [15:0] EXP_ONE     = 16'sd1;
  localparam logic [15:0] EXP_MIN     = 16'h8000;

  typedef struct packed {
    logic ld;     // capture ranges of an accepted weigh beat
    logic scale;  // register range times scale
    logic rd;     // issue table read
    logic norm;   // normalize table entry
    logic mul;    // register mantissa product
    logic upd;    // commit product update
    logic last;   // final ray of the particle
  } ctl_t;

endpackage

// ===== hw/rtl/blp_table.sv =====
// ----------------------------------------------------------------------------
// blp_table
// Likelihood table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module blp_table #(
  parameter int RANGE_BINS = blp_pkg::RANGE_BINS_DEF
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [$clog2(RANGE_BINS*RANGE_BINS)-1:0]    waddr,
  input  logic [15:0]                                 wdata,
  input  logic                                        re,
  input  logic [$clog2(RANGE_BINS*RANGE_BINS)-1:0]    raddr,
  output logic [15:0]                                 rdata
);

  localparam int DEPTH = RANGE_BINS * RANGE_BINS;

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/blp_index.sv =====
// ----------------------------------------------------------------------------
// blp_index
// Range to pixel conversion, clamping and table address generation.
// ----------------------------------------------------------------------------
module blp_index #(
  parameter int RANGE_BINS = blp_pkg::RANGE_BINS_DEF
) (
  input  logic                                        clk,
  input  blp_pkg::ctl_t                               ctl,
  input  logic [15:0]                                 measured_range,
  input  logic [15:0]                                 expected_range,
  input  logic [15:0]                                 pixels_per_metre,
  input  logic [8:0]                                  range_limit,
  output logic [$clog2(RANGE_BINS*RANGE_BINS)-1:0]    addr
);

  localparam int PXW = $clog2(RANGE_BINS);
  localparam int AW  = $clog2(RANGE_BINS*RANGE_BINS);

  logic [15:0] meas_r;
  logic [15:0] exp_r;
  logic [31:0] mprod_r;
  logic [31:0] eprod_r;

  logic [8:0]  lim9;
  logic [15:0] lim;
  logic [15:0] mpx;
  logic [15:0] epx;

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      meas_r <= measured_range;
      exp_r  <= expected_range;
    end
    if (ctl.scale) begin
      mprod_r <= 32'(meas_r) * 32'(pixels_per_metre);
      eprod_r <= 32'(exp_r) * 32'(pixels_per_metre);
    end
  end

  always_comb begin
    lim9 = (range_limit == 9'd0) ? 9'd0 : range_limit - 9'd1;
    lim  = (16'(lim9) > 16'(RANGE_BINS - 1)) ? 16'(RANGE_BINS - 1) : 16'(lim9);
    mpx  = (mprod_r[31:16] > lim) ? lim : mprod_r[31:16];
    epx  = (eprod_r[31:16] > lim) ? lim : eprod_r[31:16];
    addr = AW'(epx[PXW-1:0]) * AW'(RANGE_BINS) + AW'(mpx[PXW-1:0]);
  end

endmodule

// ===== hw/rtl/blp_accum.sv =====
// ----------------------------------------------------------------------------
// blp_accum
// Running product: entry normalize, mantissa multiply, exponent update.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blp_accum (
  input  logic           clk,
  input  logic           rst_n,
  input  blp_pkg::ctl_t  ctl,
  input  logic [15:0]    entry,
  output logic [31:0]    new_mant,
  output logic [15:0]    new_exp
);

  logic [31:0] mant_r;
  logic [15:0] exp_r;
  logic [15:0] entry_n_r;
  logic [3:0]  sh_r;
  logic [47:0] prod_r;

  logic [3:0]         msb;
  logic [3:0]         sh;
  logic signed [17:0] esum;

  always_comb begin
    msb = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (entry[i]) msb = 4'(i);
    end
    sh = 4'd15 - msb;
  end

  always_ff @(posedge clk) begin
    if (ctl.norm) begin
      entry_n_r <= entry << sh;
      sh_r      <= sh;
    end
    if (ctl.mul) begin
      prod_r <= 48'(mant_r) * 48'(entry_n_r);
    end
  end

  always_comb begin
    esum = $signed({{2{exp_r[15]}}, exp_r}) - $signed({14'd0, sh_r})
         - $signed({17'd0, ~prod_r[47]});
    if (prod_r[47:46] == 2'b00) begin
      new_mant = 32'd0;
      new_exp  = exp_r;
    end else begin
      new_mant = prod_r[47] ? prod_r[47:16] : prod_r[46:15];
      new_exp  = (esum < -18'sd32768) ? blp_pkg::EXP_MIN : esum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mant_r <= blp_pkg::MANT_ONE;
      exp_r  <= blp_pkg::EXP_ONE;
    end else if (ctl.upd) begin
      if (ctl.last) begin
        mant_r <= blp_pkg::MANT_ONE;
        exp_r  <= blp_pkg::EXP_ONE;
      end else begin
        mant_r <= new_mant;
        exp_r  <= new_exp;
      end
    end
  end

  `BLP_ASSERT(a_mant_normal, mant_r == 32'd0 || mant_r[31], "mantissa lost normalization")
  `BLP_ASSERT(a_exp_bound, $signed(exp_r) <= 16'sd1, "exponent above one")

endmodule

// ===== hw/rtl/beam_likelihood_product_unit.sv =====
// ----------------------------------------------------------------------------
// beam_likelihood_product_unit
// Particle weighting with a tabulated beam sensor model.
// ----------------------------------------------------------------------------
// A load beat (func 0) writes one table entry and does not stall the input. A
// weigh beat (func 1) stalls the input until the weigh is done: the range
// scale multiply, the table read, entry normalize, the mantissa multiply and
// the product update run one after another on one ray at a time. A result
// leaves through an output register, so the next beat is taken while it waits.
// A final ray holds in the update stage while the previous weight still waits
// in the output register.
// The table has no reset and is valid only where loaded; no clearing pass.
`include "assert_macros.svh"

module beam_likelihood_product_unit #(
  parameter int RANGE_BINS = blp_pkg::RANGE_BINS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [15:0] in_table_addr,
  input  logic [15:0] in_table_value,
  input  logic [15:0] in_measured_range,
  input  logic [15:0] in_expected_range,
  input  logic        in_last_ray,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_weight_mantissa,
  output logic [15:0] out_weight_exponent,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW    = $clog2(RANGE_BINS*RANGE_BINS);
  localparam int DEPTH = RANGE_BINS * RANGE_BINS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCALE = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_NORM  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic        last_r;
  logic [15:0] ppm_r;
  logic [8:0]  maxr_r;
  logic        out_valid_r;
  logic [31:0] out_mant_r;
  logic [15:0] out_exp_r;

  logic          in_acc;
  logic          out_blocked;
  logic [31:0]   load_addr;
  logic          tbl_we;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;
  logic [31:0]   new_mant;
  logic [15:0]   new_exp;
  logic          fin;
  blp_pkg::ctl_t ctl;

  assign in_stall    = (state_r != ST_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign out_blocked = out_valid_r && out_stall;
  assign cfg_ready   = 1'b1;
  assign load_addr   = 32'(in_table_addr);
  assign tbl_we      = in_acc && (in_func == blp_pkg::FUNC_LOAD) && (load_addr < 32'(DEPTH));
  assign fin         = (state_r == ST_UPD) && !(last_r && out_blocked);

  always_comb begin
    ctl.ld    = in_acc && (in_func == blp_pkg::FUNC_WEIGH);
    ctl.scale = (state_r == ST_SCALE);
    ctl.rd    = (state_r == ST_ADDR);
    ctl.norm  = (state_r == ST_NORM);
    ctl.mul   = (state_r == ST_MUL);
    ctl.upd   = fin;
    ctl.last  = last_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (ctl.ld) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_NORM;
      ST_NORM:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_UPD;
      ST_UPD:   if (fin) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      last_r <= in_last_ray;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppm_r  <= blp_pkg::PPM_RESET;
      maxr_r <= blp_pkg::MAXR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        blp_pkg::CFG_PIXELS_PER_METRE: ppm_r  <= cfg_data;
        blp_pkg::CFG_RANGE_LIMIT:      maxr_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin && last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && last_r) begin
      out_mant_r <= new_mant;
      out_exp_r  <= (new_mant == 32'd0) ? 16'd0 : new_exp;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_weight_mantissa = out_mant_r;
  assign out_weight_exponent = out_exp_r;

  blp_index #(.RANGE_BINS(RANGE_BINS)) u_index (
    .clk              (clk),
    .ctl              (ctl),
    .measured_range   (in_measured_range),
    .expected_range   (in_expected_range),
    .pixels_per_metre (ppm_r),
    .range_limit      (maxr_r),
    .addr             (rd_addr)
  );

  blp_table #(.RANGE_BINS(RANGE_BINS)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (load_addr[AW-1:0]),
    .wdata (in_table_value),
    .re    (ctl.rd),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  blp_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .entry    (rd_data),
    .new_mant (new_mant),
    .new_exp  (new_exp)
  );

  `BLP_ASSERT_NEXT(a_weigh_starts, ctl.ld, state_r == ST_SCALE, "weigh beat did not start")
  `BLP_ASSERT_NEXT(a_result_loaded, fin && last_r, out_valid_r, "final ray gave no result")
  `BLP_ASSERT(a_zero_exp, !out_valid_r || |out_mant_r || out_exp_r == '0, "zero weight exponent")

endmodule

// ===== test/beam_likelihood_product_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// beam_likelihood_product_unit_tb
// Self-checking bench for the beam likelihood product unit.
// ----------------------------------------------------------------------------
// Starts with a table of directed beats: table corners, zero entries, scale
// truncation and known weights. Then it runs random particles over several
// scale and range settings, including zero scale and zero range. A long
// particle of tiny likelihoods drives the exponent far negative. A local
// product model predicts every weight that a directed row does not give. Each
// weight beat is checked field by field, in order. Random bursts of input gaps
// and output stalls are inserted, and the final part runs without them.
// ----------------------------------------------------------------------------
module beam_likelihood_product_unit_tb;
  import blp_pkg::*;

  localparam int RB = RANGE_BINS_DEF;
  localparam int TAW = $clog2(RB * RB);
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 100;
  localparam int TINY_RAYS = 240;
  localparam int DIR_N = 16;
  localparam int PHASE_N = 7;

  typedef struct packed {
    logic        func;
    logic [15:0] addr;
    logic [15:0] value;
    logic [15:0] meas;
    logic [15:0] expr;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic [31:0] mant;
    logic [15:0] expo;
  } weight_t;

  typedef struct packed {
    beat_t   b;
    logic    typed;
    weight_t w;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = 1'b0;
  logic [15:0] in_table_addr = '0;
  logic [15:0] in_table_value = '0;
  logic [15:0] in_measured_range = '0;
  logic [15:0] in_expected_range = '0;
  logic        in_last_ray = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_weight_mantissa;
  logic [15:0] out_weight_exponent;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  beam_likelihood_product_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_table_addr       (in_table_addr),
    .in_table_value      (in_table_value),
    .in_measured_range   (in_measured_range),
    .in_expected_range   (in_expected_range),
    .in_last_ray         (in_last_ray),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_weight_mantissa (out_weight_mantissa),
    .out_weight_exponent (out_weight_exponent),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // product model state
  logic [15:0]        lk_table [0:RB*RB-1];
  bit                 loaded [0:RB*RB-1];
  logic [15:0]        ppm = PPM_RESET;
  logic [8:0]         maxr = MAXR_RESET;
  logic [31:0]        prod_mant = MANT_ONE;
  logic signed [15:0] prod_exp = EXP_ONE;

  weight_t weight_q[$];
  weight_t want;
  int      mismatches = 0;
  int      cycle_count = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  int      stall_left = 0;

  dir_row_t dir_rows [0:DIR_N-1] = '{
    '{'{FUNC_LOAD,  16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b1}, 1'b0, '{32'h0, 16'h0}},
    '{'{FUNC_WEIGH, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b1,
      '{32'h8000_0000, 16'h0000}},
    '{'{FUNC_LOAD,  16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0}, 1'b0, '{32'h0, 16'h0}},
    '{'{FUNC_WEIGH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1,
      '{32'hFFFF_0000, 16'h0000}},
    '{'{FUNC_LOAD,  16'h0001, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b0, '{32'h0, 16'h0}},
    '{'{FUNC_WEIGH, 16'h0000, 16'h0000, 16'h000D, 16'h0000, 1'b0}, 1'b0, '{32'h0, 16'h0}},
    '{'{FUNC_WEIGH, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b1,
      '{32'h0000_0000, 16'h0000}},
    '{'{FUNC_LOAD,  16'h0100, 16'h0001, 16'h0000, 16'h0000, 1'b0}, 1'b0, '{32'h0, 16'h0}},
    '{'{FUNC_WEIGH, 16'h0000, 16'h0000, 16'h0000, 16'h000D, 1'b1}, 1'b1,
      '{32'h8000_0000, 16'hFFF1}},
    '{'{FUNC_WEIGH, 16'h0000, 16'h0000, 16'h000C, 16'h000C, 1'b1}, 1'b1,
      '{32'h8000_0000, 16'h0000}},
    '{'{FUNC_LOAD,  16'h1414, 16'hC000, 16'h0000, 16'h0000, 1'b1}, 1'b0, '{32'h0, 16'h0}},
    '{'{FUNC_WEIGH, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0}, 1'b0, '{32'h0, 16'h0}},
    '{'{FUNC_WEIGH, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b0, '{32'h0, 16'h0}},
    '{'{FUNC_WEIGH, 16'h0000, 16'h0000, 16'h0000, 16'h000D, 1'b0}, 1'b0, '{32'h0, 16'h0}},
    '{'{FUNC_WEIGH, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b1}, 1'b0, '{32'h0, 16'h0}},
    '{'{FUNC_LOAD,  16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b1}, 1'b0, '{32'h0, 16'h0}}
  };

  logic [15:0] phase_ppm  [0:PHASE_N-1] = '{16'd0, 16'd65535, 16'd1, 16'd256,
                                           16'd3000, 16'd65535, 16'd5120};
  logic [8:0]  phase_maxr [0:PHASE_N-1] = '{9'd256, 9'd256, 9'd1, 9'd0,
                                           9'd100, 9'd511, 9'd256};
  int          phase_idle [0:PHASE_N-1] = '{20, 30, 10, 0, 40, 15, 25};

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int range_px(logic [15:0] r);
    logic [31:0] scaled;
    int          px;
    int          lim;
    scaled = 32'(r) * 32'(ppm);
    px = int'(scaled[31:16]);
    lim = (maxr == 0) ? 0 : int'(maxr) - 1;
    if (lim > RB - 1) lim = RB - 1;
    if (px > lim) px = lim;
    return px;
  endfunction

  function automatic logic [TAW-1:0] entry_index(beat_t b);
    return TAW'(range_px(b.expr) * RB + range_px(b.meas));
  endfunction

  function automatic void mul_entry(logic [15:0] entry);
    logic [47:0] p;
    int          k;
    int          e;
    p = 48'(prod_mant) * 48'(entry);
    if (p == 0) begin
      prod_mant = '0;
      return;
    end
    k = 47;
    while (!p[k]) k--;
    if (k >= 31) prod_mant = 32'(p >> (k - 31));
    else prod_mant = 32'(p << (31 - k));
    e = int'(prod_exp) + k - 47;
    if (e < -32768) e = -32768;
    prod_exp = 16'(e);
  endfunction

  function automatic bit apply_beat(beat_t b, output weight_t w);
    w = '0;
    if (b.func == FUNC_LOAD) begin
      if (int'(b.addr) < RB * RB) begin
        lk_table[b.addr] = b.value;
        loaded[b.addr] = 1'b1;
      end
      return 1'b0;
    end
    mul_entry(lk_table[entry_index(b)]);
    if (!b.last) return 1'b0;
    w.mant = prod_mant;
    w.expo = (prod_mant == 0) ? 16'h0000 : prod_exp;
    prod_mant = MANT_ONE;
    prod_exp = EXP_ONE;
    return 1'b1;
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 255));
      default: return 16'($urandom_range(16'h4000, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] rand_range();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom());
      default: return 16'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic beat_t rand_beat(logic func);
    beat_t b;
    b.func  = func;
    b.addr  = 16'($urandom());
    b.value = rand_value();
    b.meas  = rand_range();
    b.expr  = rand_range();
    b.last  = 1'($urandom());
    return b;
  endfunction

  task automatic send_beat(beat_t b, logic typed, weight_t typed_w);
    weight_t w;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= b.func;
    in_table_addr     <= b.addr;
    in_table_value    <= b.value;
    in_measured_range <= b.meas;
    in_expected_range <= b.expr;
    in_last_ray       <= b.last;
    do @(posedge clk); while (in_stall);
    if (apply_beat(b, w)) weight_q.push_back(typed ? typed_w : w);
  endtask

  task automatic write_config(logic [15:0] new_ppm, logic [8:0] new_maxr);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PIXELS_PER_METRE;
    cfg_data  <= new_ppm;
    do @(posedge clk); while (!cfg_ready);
    ppm = new_ppm;
    cfg_index <= CFG_RANGE_LIMIT;
    cfg_data  <= {7'd0, new_maxr};
    do @(posedge clk); while (!cfg_ready);
    maxr = new_maxr;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (weight_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_particles(int n_items);
    int             sent;
    int             rays;
    logic [TAW-1:0] idx;
    beat_t          b;
    beat_t          ld;
    sent = 0;
    while (sent < n_items) begin
      rays = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int r = 0; r < rays; r++) begin
        // stray load between rays
        if ($urandom_range(0, 4) == 0) begin
          send_beat(rand_beat(FUNC_LOAD), 1'b0, '0);
          sent++;
        end
        b = rand_beat(FUNC_WEIGH);
        b.last = (r == rays - 1);
        idx = entry_index(b);
        if (!loaded[idx]) begin
          ld = rand_beat(FUNC_LOAD);
          ld.addr = 16'(idx);
          send_beat(ld, 1'b0, '0);
          sent++;
        end
        send_beat(b, 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (weight_q.size() == 0) begin
        $error("weight beat with none expected: mantissa %h exponent %h",
               out_weight_mantissa, out_weight_exponent);
        mismatches++;
      end else begin
        want = weight_q.pop_front();
        if (out_weight_mantissa !== want.mant) begin
          $error("weight_mantissa: expected %h, got %h", want.mant, out_weight_mantissa);
          mismatches++;
        end
        if (out_weight_exponent !== want.expo) begin
          $error("weight_exponent: expected %h, got %h", want.expo, out_weight_exponent);
          mismatches++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    beat_t b;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    gap_pct = 20;
    stall_pct = 20;
    for (int i = 0; i < DIR_N; i++) begin
      send_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].w);
    end
    drain();

    for (int ph = 0; ph < PHASE_N; ph++) begin
      gap_pct = phase_idle[ph];
      stall_pct = phase_idle[ph];
      write_config(phase_ppm[ph], phase_maxr[ph]);
      random_particles(PHASE_ITEMS);
      drain();
    end

    // long particle of the smallest nonzero likelihood
    gap_pct = 0;
    stall_pct = 0;
    write_config(PPM_RESET, MAXR_RESET);
    b = rand_beat(FUNC_LOAD);
    b.addr = 16'h0000;
    b.value = 16'h0001;
    send_beat(b, 1'b0, '0);
    for (int i = 0; i < TINY_RAYS; i++) begin
      b = rand_beat(FUNC_WEIGH);
      b.meas = 16'($urandom_range(0, 12));
      b.expr = 16'($urandom_range(0, 12));
      b.last = (i == TINY_RAYS - 1);
      send_beat(b, 1'b0, '0);
    end
    random_particles(100);
    drain();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
